// ===== rtl/core/dfasr_pkg.sv =====
// dfasr_pkg: widths, codes and shared structs of the DFA string recognizer.
// No dependencies; every other file of the block imports it.
package dfasr_pkg;

  // Field and table geometry
  localparam int STATE_W      = 6;
  localparam int SLOT_W       = 7;
  localparam int CHAR_W       = 8;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int NSTATES_W    = 7;
  localparam int NSYM_W       = 8;
  localparam int STATE_COUNT  = 1 << STATE_W;
  localparam int SYMBOL_SLOTS = 1 << SLOT_W;
  localparam int COUNT_W      = SLOT_W + 1;
  localparam int TRANS_AW     = STATE_W + SLOT_W;
  localparam int TRANS_DEPTH  = STATE_COUNT * SYMBOL_SLOTS;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRANS  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ACCEPT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EMPTY  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  // Transition table entry
  typedef struct packed {
    logic               vld;
    logic [STATE_W-1:0] nxt;
  } trans_entry_t;

  // Input item as held in the first stage
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic               last_char;
    logic [STATE_W-1:0] src_state;
    logic [SLOT_W-1:0]  symbol_slot;
    logic [STATE_W-1:0] dst_state;
  } a_item_t;

  // Item as handed to the second stage
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                last;
    logic                ch_zero;
    logic                lookup_ok;
    logic [STATE_W-1:0]  st_eff;
    logic                rej_eff;
    logic                zs_eff;
    logic [SLOT_W-1:0]   ins_slot;
    logic [STATUS_W-1:0] ins_status;
  } b_item_t;

  // Symbol map lookup
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic [SLOT_W-1:0] tail;
  } sym_lookup_t;

  // String tracking state
  typedef struct packed {
    logic               open;
    logic [STATE_W-1:0] cur;
    logic               rej;
    logic               zs;
  } trk_state_t;

  // String result
  typedef struct packed {
    logic                accepted;
    logic [STATUS_W-1:0] status;
  } trk_result_t;

endpackage

// ===== rtl/core/dfasr_ifs.sv =====
// dfasr_ifs: valid/ready channel interfaces of the DFA string recognizer
// (input items, result items, configuration writes). Depends on dfasr_pkg.

interface dfasr_item_if;
  import dfasr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   char_code;
  logic                last_char;
  logic [STATE_W-1:0]  src_state;
  logic [SLOT_W-1:0]   symbol_slot;
  logic [STATE_W-1:0]  dst_state;

  modport source (output valid, mode, char_code, last_char, src_state, symbol_slot,
                  dst_state, input ready);
  modport sink   (input valid, mode, char_code, last_char, src_state, symbol_slot,
                  dst_state, output ready);
endinterface

interface dfasr_result_if;
  import dfasr_pkg::*;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, accepted, slot_out, status, input ready);
  modport sink   (input valid, accepted, slot_out, status, output ready);
endinterface

interface dfasr_cfg_if;
  import dfasr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dfasr_symmap.sv =====
// dfasr_symmap: character-to-slot map, a parallel match over all slots plus
// an append port. Depends on dfasr_pkg.
module dfasr_symmap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dfasr_pkg::CHAR_W-1:0]  ch,
  input  logic                          ins_req,
  output dfasr_pkg::sym_lookup_t        lk
);
  import dfasr_pkg::*;

  logic [CHAR_W-1:0]       chars [SYMBOL_SLOTS];
  logic [SYMBOL_SLOTS-1:0] vld;
  logic [COUNT_W-1:0]      count;
  logic                    hit;
  logic [SLOT_W-1:0]       slot;
  logic                    full;
  logic                    append;

  // Parallel compare; stored characters are unique, so at most one hits
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      if (vld[i] && (chars[i] == ch)) begin
        hit  = 1'b1;
        slot = slot | SLOT_W'(i);
      end
    end
  end

  assign full   = (count == COUNT_W'(SYMBOL_SLOTS));
  assign append = ins_req && (ch != '0) && !hit && !full;

  assign lk.hit  = hit;
  assign lk.slot = slot;
  assign lk.full = full;
  assign lk.tail = count[SLOT_W-1:0];

  // Fill count and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      vld   <= '0;
    end else if (append) begin
      vld[count[SLOT_W-1:0]] <= 1'b1;
      count                  <= count + COUNT_W'(1);
    end
  end

  // Character storage
  always_ff @(posedge clk) begin
    if (append) begin
      chars[count[SLOT_W-1:0]] <= ch;
    end
  end

endmodule

// ===== rtl/core/dfasr_trans_mem.sv =====
// dfasr_trans_mem: transition table memory, one write and one registered
// read port, with an invalidating sweep after reset. Depends on dfasr_pkg.
module dfasr_trans_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [dfasr_pkg::TRANS_AW-1:0] wr_addr,
  input  dfasr_pkg::trans_entry_t        wr_data,
  input  logic                           rd_en,
  input  logic [dfasr_pkg::TRANS_AW-1:0] rd_addr,
  output dfasr_pkg::trans_entry_t        rd_data,
  output logic                           busy
);
  import dfasr_pkg::*;

  trans_entry_t        mem [TRANS_DEPTH];
  logic [TRANS_AW-1:0] clr_addr;

  // Clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      clr_addr <= clr_addr + TRANS_AW'(1);
      if (clr_addr == TRANS_AW'(TRANS_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/dfasr_tracker.sv =====
// dfasr_tracker: second stage, applies a transition to the string state
// and holds the accept flags. Depends on dfasr_pkg.
module dfasr_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  dfasr_pkg::b_item_t            b,
  input  dfasr_pkg::trans_entry_t       rd,
  input  logic [dfasr_pkg::STATE_W-1:0] init_state,
  input  logic                          flag_we,
  input  logic [dfasr_pkg::STATE_W-1:0] flag_addr,
  output dfasr_pkg::trk_state_t         trk,
  output dfasr_pkg::trk_result_t        res
);
  import dfasr_pkg::*;

  logic [STATE_COUNT-1:0] flags;
  logic [STATE_W-1:0]     nxt_cur;
  logic                   nxt_rej;
  logic                   nxt_zs;
  logic [STATE_W-1:0]     flag_rd;

  // Step the automaton for a string character
  always_comb begin
    nxt_cur = b.st_eff;
    nxt_rej = b.rej_eff;
    nxt_zs  = b.zs_eff;
    if (!b.rej_eff) begin
      if (b.ch_zero) begin
        nxt_zs  = 1'b1;
        nxt_rej = 1'b1;
      end else if (!b.lookup_ok || !rd.vld) begin
        nxt_rej = 1'b1;
      end else begin
        nxt_cur = rd.nxt;
      end
    end else if (b.ch_zero) begin
      nxt_zs = 1'b1;
    end
  end

  // Result: an empty string reports the start state's flag
  assign flag_rd      = (b.mode == MODE_EMPTY) ? init_state : nxt_cur;
  assign res.accepted = flags[flag_rd] && ((b.mode == MODE_EMPTY) || !nxt_rej);
  assign res.status   = ((b.mode == MODE_CHAR) && nxt_zs) ? ST_ZERO : ST_OK;

  // String state
  always_ff @(posedge clk) begin
    if (rst) begin
      trk <= '0;
    end else if (adv) begin
      unique case (b.mode)
        MODE_CHAR: begin
          trk.open <= !b.last;
          trk.cur  <= nxt_cur;
          trk.rej  <= nxt_rej;
          trk.zs   <= nxt_zs;
        end
        MODE_EMPTY: begin
          trk.open <= 1'b0;
          trk.cur  <= init_state;
          trk.rej  <= 1'b0;
          trk.zs   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Accept flags, set only
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (flag_we) begin
      flags[flag_addr] <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/dfa_string_recognizer.sv =====
// dfa_string_recognizer: top level, two-stage pipeline around the symbol map,
// transition memory and string tracker. Depends on dfasr_pkg, dfasr_ifs and the
// dfasr_symmap, dfasr_trans_mem and dfasr_tracker modules.
//
// Table-driven DFA recognizer. Items enter through a valid/ready channel; an
// item that gives a result passes the stage A, stage B and output registers.
// A string character taken right behind another character or an
// empty-string item waits in stage A until that item has left stage B: a
// character's transition address needs the state returned by the previous
// character's registered transition memory read. Inserts, table writes and
// empty-string items are taken one per cycle while the result output does
// not stall. After reset the block invalidates the 8192-entry transition
// memory, one entry per cycle, and takes no items until that sweep is done;
// configuration writes are taken at any time, with ready always high, and
// should be done while the block is idle.
module dfa_string_recognizer (
  input  logic          clk,
  input  logic          rst,
  dfasr_item_if.sink    item,
  dfasr_result_if.source result,
  dfasr_cfg_if.sink     cfg
);
  import dfasr_pkg::*;

  // Configuration registers
  logic [NSTATES_W-1:0] state_limit;
  logic [NSYM_W-1:0]    symbol_limit;
  logic [STATE_W-1:0]   init_state;

  // Pipeline registers
  logic        a_vld;
  a_item_t     a;
  logic        b_vld;
  b_item_t     b;
  b_item_t     b_next;
  logic        o_vld;
  logic        o_accepted;
  logic [SLOT_W-1:0]   o_slot;
  logic [STATUS_W-1:0] o_status;

  // Control
  logic         item_take;
  logic         a_adv;
  logic         b_adv;
  logic         b_res;
  logic         hazard;
  logic         clr_busy;
  sym_lookup_t  lk;
  trk_state_t   trk;
  trk_result_t  tres;
  trans_entry_t rd_data;
  trans_entry_t wr_data;
  logic         trans_we;
  logic         flag_we;
  logic [STATE_W-1:0] st_eff;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_limit  <= NSTATES_W'(1);
      symbol_limit <= '0;
      init_state   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_NUM_STATES:  state_limit  <= cfg.data[NSTATES_W-1:0];
        CFG_NUM_SYMBOLS: symbol_limit <= cfg.data[NSYM_W-1:0];
        CFG_START_STATE: init_state   <= cfg.data[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage movement
  assign b_res = b_vld && ((b.mode == MODE_INSERT) || (b.mode == MODE_EMPTY) ||
                           ((b.mode == MODE_CHAR) && b.last));
  assign b_adv = b_vld && (!b_res || !o_vld || result.ready);
  assign hazard = (a.mode == MODE_CHAR) && b_vld &&
                  ((b.mode == MODE_CHAR) || (b.mode == MODE_EMPTY));
  assign a_adv = a_vld && (!b_vld || b_adv) && !hazard;
  assign item.ready = !clr_busy && (!a_vld || a_adv);
  assign item_take  = item.valid && item.ready;

  // Stage A register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (item_take) begin
      a_vld <= 1'b1;
    end else if (a_adv) begin
      a_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      a.mode        <= item.mode;
      a.char_code   <= item.char_code;
      a.last_char   <= item.last_char;
      a.src_state   <= item.src_state;
      a.symbol_slot <= item.symbol_slot;
      a.dst_state   <= item.dst_state;
    end
  end

  // Stage A: symbol lookup, insert, table writes, transition read issue
  dfasr_symmap u_symmap (
    .clk     (clk),
    .rst     (rst),
    .ch      (a.char_code),
    .ins_req (a_adv && (a.mode == MODE_INSERT)),
    .lk      (lk)
  );

  assign st_eff = trk.open ? trk.cur : init_state;

  always_comb begin
    b_next            = '0;
    b_next.mode       = a.mode;
    b_next.last       = a.last_char;
    b_next.ch_zero    = (a.char_code == '0);
    b_next.lookup_ok  = lk.hit && ({1'b0, lk.slot} < symbol_limit);
    b_next.st_eff     = st_eff;
    b_next.rej_eff    = trk.open && trk.rej;
    b_next.zs_eff     = trk.open && trk.zs;
    priority if (a.char_code == '0) begin
      b_next.ins_status = ST_ZERO;
    end else if (lk.hit) begin
      b_next.ins_slot   = lk.slot;
      b_next.ins_status = ST_OK;
    end else if (lk.full) begin
      b_next.ins_status = ST_FULL;
    end else begin
      b_next.ins_slot   = lk.tail;
      b_next.ins_status = ST_OK;
    end
  end

  assign trans_we = a_adv && (a.mode == MODE_TRANS) &&
                    ({1'b0, a.src_state} < state_limit) &&
                    ({1'b0, a.symbol_slot} < symbol_limit) &&
                    ({1'b0, a.dst_state} < state_limit);
  assign wr_data.vld = 1'b1;
  assign wr_data.nxt = a.dst_state;
  assign flag_we = a_adv && (a.mode == MODE_ACCEPT) &&
                   ({1'b0, a.src_state} < state_limit);

  dfasr_trans_mem u_trans_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (trans_we),
    .wr_addr ({a.src_state, a.symbol_slot}),
    .wr_data (wr_data),
    .rd_en   (a_adv),
    .rd_addr ({st_eff, lk.slot}),
    .rd_data (rd_data),
    .busy    (clr_busy)
  );

  // Stage B register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (a_adv) begin
      b_vld <= 1'b1;
    end else if (b_adv) begin
      b_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b <= b_next;
    end
  end

  // Stage B: state update and accept flags
  dfasr_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .adv        (b_adv),
    .b          (b),
    .rd         (rd_data),
    .init_state (init_state),
    .flag_we    (flag_we),
    .flag_addr  (a.src_state),
    .trk        (trk),
    .res        (tres)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (b_adv && b_res) begin
      o_vld <= 1'b1;
    end else if (result.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_res) begin
      if (b.mode == MODE_INSERT) begin
        o_accepted <= 1'b0;
        o_slot     <= b.ins_slot;
        o_status   <= b.ins_status;
      end else begin
        o_accepted <= tres.accepted;
        o_slot     <= '0;
        o_status   <= tres.status;
      end
    end
  end

  assign result.valid    = o_vld;
  assign result.accepted = o_accepted;
  assign result.slot_out = o_slot;
  assign result.status   = o_status;

endmodule

// ===== rtl/core/dfasr_checker.sv =====
// dfasr_assertions: port-level assertions of the DFA string recognizer, bound
// to the top level. Depends on dfasr_pkg and dfa_string_recognizer.
module dfasr_assertions (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           accepted,
  input logic [dfasr_pkg::SLOT_W-1:0]   slot_out,
  input logic [dfasr_pkg::STATUS_W-1:0] status
);
  import dfasr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted) &&
                                $stable(slot_out) && $stable(status))
    else $error("result changed while stalled");

  // Reset starts the clearing sweep and empties the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("items taken or results shown right after reset");

  // Error results carry no slot and no acceptance
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (slot_out == '0) && !accepted)
    else $error("error result with slot or acceptance");

  // Acceptance only comes from strings, which carry slot zero
  a_acc_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> (slot_out == '0) && (status == ST_OK))
    else $error("accepted result with slot or error");

endmodule

bind dfa_string_recognizer dfasr_assertions u_dfasr_assertions (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .accepted  (result.accepted),
  .slot_out  (result.slot_out),
  .status    (result.status)
);
